// ===== sv/bgu_pkg.sv =====
// Shared types, constants and the sigmoid table for the Gibbs unit update block.
`timescale 1ns / 1ps

package bgu_pkg;

  localparam int CMD_W   = 2;
  localparam int ROW_W   = 3;
  localparam int VAL_W   = 16;
  localparam int RND_W   = 16;
  localparam int PART_W  = 8;
  localparam int FIELD_W = 21;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam int FIELD_MAX = 1048575;
  localparam int FIELD_MIN = -1048576;

  // Offset that moves the field onto the table index grid (8 in Q.12).
  localparam int LUT_OFFSET = 32768;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_WEIGHT = 2'd0,
    CMD_WRITE_BIAS   = 2'd1,
    CMD_CLEAR        = 2'd2,
    CMD_UPDATE       = 2'd3
  } cmd_e;

  typedef logic [255:0][15:0] sig_rom_t;

  // Restoring long division; only evaluated while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry k stands for x = (k - 128) / 16; built once at elaboration.
  function automatic sig_rom_t build_sig_rom();
    logic [63:0] e [0:128];
    logic [63:0] den;
    logic [63:0] q;
    int          m;
    sig_rom_t    rom;
    e[0] = 64'd1 << 30;
    for (int n = 0; n < 128; n++) begin
      e[n+1] = (e[n] * 64'd1008687096 + (64'd1 << 29)) >> 30;
    end
    for (int k = 0; k < 256; k++) begin
      m   = (k >= 128) ? k - 128 : 128 - k;
      den = (64'd1 << 30) + e[m];
      q   = udiv64((64'd1 << 46) + (den >> 1), den);
      if (k >= 128) begin
        rom[k] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
      end else begin
        rom[k] = 16'(64'd65536 - q);
      end
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== sv/bgu_sat_add.sv =====
// Shared adder/subtractor with saturation to the local field range.
`timescale 1ns / 1ps

module bgu_sat_add #(
  parameter int OP_W = 21
) (
  input  logic signed [bgu_pkg::FIELD_W-1:0] a_i,
  input  logic signed [OP_W-1:0]             b_i,
  input  logic                               sub_i,
  output logic signed [OP_W:0]               sum_o,
  output logic signed [bgu_pkg::FIELD_W-1:0] sat_o
);

  localparam logic signed [OP_W:0] MaxX = (OP_W+1)'(bgu_pkg::FIELD_MAX);
  localparam logic signed [OP_W:0] MinX = (OP_W+1)'(bgu_pkg::FIELD_MIN);

  logic signed [OP_W:0] a_ext;
  logic signed [OP_W:0] b_ext;

  assign a_ext = {{(OP_W+1-bgu_pkg::FIELD_W){a_i[bgu_pkg::FIELD_W-1]}}, a_i};
  assign b_ext = {b_i[OP_W-1], b_i};
  assign sum_o = a_ext + (sub_i ? ~b_ext : b_ext) + {{OP_W{1'b0}}, sub_i};

  always_comb begin
    if (sum_o > MaxX) begin
      sat_o = bgu_pkg::FIELD_W'(bgu_pkg::FIELD_MAX);
    end else if (sum_o < MinX) begin
      sat_o = bgu_pkg::FIELD_W'(bgu_pkg::FIELD_MIN);
    end else begin
      sat_o = sum_o[bgu_pkg::FIELD_W-1:0];
    end
  end

endmodule

// ===== sv/boltzmann_gibbs_unit_update.sv =====
// Top level: Gibbs sampler unit update for a fully connected binary Boltzmann machine.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser: command; tdata: row, column,
//                                                weight_value, uniform_random
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: particle, new_bit, local_field
// cfg       in   cfg_valid_i/cfg_ready_o          cfg_data_i: bias_mode
//
// Sequence: an update steps through S_ACC for every unit, with an S_BIAS step after each
// active unit when bias_mode is 1, then S_LOOK and S_DONE; one weight read from the
// weight RAM and one pass through the shared adder per step set this pace.
// A weight write steps through S_WR1 and S_WR2 (two RAM writes) to S_DONE; other
// commands go straight from accept to S_DONE.
// Reset: after rst_ni rises the RAMs are swept to zero, one entry a cycle, over all
// 2**(2*clog2(UNITS)) weight addresses (64 at UNITS = 8); no item is accepted meanwhile.
// Stalls: the result sits in an output register; a new item is accepted while it
// waits, and the finished next result holds until the register frees up.

module boltzmann_gibbs_unit_update #(
  parameter int UNITS       = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // [2:0] row_index, [5:3] column_index, [21:6] weight_value,
  // [37:22] uniform_random, [39:38] zero
  input  logic [bgu_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [1:0] command
  input  logic [bgu_pkg::CMD_W-1:0]          s_axis_tuser_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] particle, [8] new_bit, [29:9] local_field, [31:30] zero
  output logic [bgu_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic                               cfg_data_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o
);

  localparam int RW    = $clog2(UNITS);
  localparam int AW    = 2 * RW;
  localparam int WDEP  = 2 ** AW;
  localparam int BDEP  = 2 ** RW;
  localparam int OP_W  = (WEIGHT_BITS + 1 > bgu_pkg::FIELD_W) ? WEIGHT_BITS + 1
                                                              : bgu_pkg::FIELD_W;
  localparam logic [RW-1:0] LAST_J = RW'(UNITS - 1);
  localparam logic signed [32:0] W_HI = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WR1   = 3'd2;
  localparam logic [2:0] S_WR2   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_BIAS  = 3'd5;
  localparam logic [2:0] S_LOOK  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // ---------------------------------------------------------------------------
  // Input unpack
  // ---------------------------------------------------------------------------
  logic [bgu_pkg::ROW_W-1:0]     in_row;
  logic [bgu_pkg::ROW_W-1:0]     in_col;
  logic signed [bgu_pkg::VAL_W-1:0] in_val;
  logic [bgu_pkg::RND_W-1:0]     in_rnd;
  bgu_pkg::cmd_e                 in_cmd;
  logic signed [32:0]            in_val_x;
  logic signed [32:0]            in_val_sat;
  logic signed [WEIGHT_BITS-1:0] in_val_w;
  logic                          in_row_ok;
  logic                          in_col_ok;
  logic                          in_acc;

  assign in_row = s_axis_tdata_i[2:0];
  assign in_col = s_axis_tdata_i[5:3];
  assign in_val = s_axis_tdata_i[21:6];
  assign in_rnd = s_axis_tdata_i[37:22];
  assign in_cmd = bgu_pkg::cmd_e'(s_axis_tuser_i);

  // Saturate the written value into the store width.
  assign in_val_x = 33'(in_val);
  always_comb begin
    if (in_val_x > W_HI) begin
      in_val_sat = W_HI;
    end else if (in_val_x < W_LO) begin
      in_val_sat = W_LO;
    end else begin
      in_val_sat = in_val_x;
    end
  end
  assign in_val_w  = in_val_sat[WEIGHT_BITS-1:0];

  assign in_row_ok = ({29'd0, in_row} < 32'(UNITS));
  assign in_col_ok = ({29'd0, in_col} < 32'(UNITS));
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [2:0]                       state_q, state_d;
  logic [AW-1:0]                    clr_q, clr_d;
  logic [bgu_pkg::ROW_W-1:0]        row_q, row_d;
  logic [bgu_pkg::ROW_W-1:0]        col_q, col_d;
  bgu_pkg::cmd_e                    cmd_q, cmd_d;
  logic signed [WEIGHT_BITS-1:0]    val_q, val_d;
  logic [bgu_pkg::RND_W-1:0]        rnd_q, rnd_d;
  logic [RW-1:0]                    j_q, j_d;
  logic signed [bgu_pkg::FIELD_W-1:0] field_q, field_d;
  logic                             bit_q, bit_d;
  logic [UNITS-1:0]                 particle_q, particle_d;
  logic                             bias_mode_q;
  logic                             out_valid_q, out_valid_d;
  logic [bgu_pkg::OUT_DATA_W-1:0]   out_data_q, out_data_d;

  // RAMs and their registered read data
  logic [WEIGHT_BITS-1:0]           wmem [WDEP];
  logic [WEIGHT_BITS-1:0]           bmem [BDEP];
  logic signed [WEIGHT_BITS-1:0]    wrd_q;
  logic signed [WEIGHT_BITS-1:0]    brd_q;

  // Row/column narrowed to the RAM index width
  logic [bgu_pkg::ROW_W+RW-1:0]     row_d_x, row_q_x, col_q_x, in_row_x;
  logic [RW-1:0]                    row_d_a, row_q_a, col_q_a, in_row_a;

  assign row_d_x  = {{RW{1'b0}}, row_d};
  assign row_q_x  = {{RW{1'b0}}, row_q};
  assign col_q_x  = {{RW{1'b0}}, col_q};
  assign in_row_x = {{RW{1'b0}}, in_row};
  assign row_d_a  = row_d_x[RW-1:0];
  assign row_q_a  = row_q_x[RW-1:0];
  assign col_q_a  = col_q_x[RW-1:0];
  assign in_row_a = in_row_x[RW-1:0];

  // ---------------------------------------------------------------------------
  // Shared adder
  // ---------------------------------------------------------------------------
  logic signed [OP_W-1:0]             alu_b;
  logic                               alu_sub;
  logic signed [OP_W:0]               alu_sum;
  logic signed [bgu_pkg::FIELD_W-1:0] alu_sat;

  always_comb begin
    alu_sub = 1'b0;
    alu_b   = {{(OP_W-WEIGHT_BITS){wrd_q[WEIGHT_BITS-1]}}, wrd_q};
    case (state_q)
      S_BIAS: begin
        alu_sub = 1'b1;
        alu_b   = {{(OP_W-WEIGHT_BITS){brd_q[WEIGHT_BITS-1]}}, brd_q};
      end
      S_LOOK: begin
        alu_b = OP_W'(bgu_pkg::LUT_OFFSET);
      end
      default: begin
      end
    endcase
  end

  bgu_sat_add #(
    .OP_W (OP_W)
  ) u_add (
    .a_i   (field_q),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .sat_o (alu_sat)
  );

  // Table index: clamp to the low end when negative, to the top from 8.0 up
  logic [7:0]  lut_idx;
  logic [15:0] lut_prob;
  logic        draw_bit;

  always_comb begin
    if (alu_sum[OP_W]) begin
      lut_idx = 8'd0;
    end else if (|alu_sum[OP_W-1:16]) begin
      lut_idx = 8'hFF;
    end else begin
      lut_idx = alu_sum[15:8];
    end
  end
  assign lut_prob = bgu_pkg::SIG_ROM[lut_idx];
  assign draw_bit = (lut_prob > rnd_q);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  localparam int PART_PAD = bgu_pkg::PART_W;
  logic [UNITS+PART_PAD-1:0] part_x;
  logic                      out_free;

  assign part_x   = {{PART_PAD{1'b0}}, particle_d};
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    row_d       = row_q;
    col_d       = col_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    rnd_d       = rnd_q;
    j_d         = j_q;
    field_d     = field_q;
    bit_d       = bit_q;
    particle_d  = particle_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == {AW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          row_d   = in_row;
          col_d   = in_col;
          cmd_d   = in_cmd;
          val_d   = in_val_w;
          rnd_d   = in_rnd;
          j_d     = '0;
          field_d = '0;
          bit_d   = 1'b0;
          state_d = S_DONE;
          case (in_cmd)
            bgu_pkg::CMD_WRITE_WEIGHT: begin
              if (in_row_ok && in_col_ok) begin
                state_d = S_WR1;
              end
            end
            bgu_pkg::CMD_CLEAR: begin
              particle_d = '0;
            end
            bgu_pkg::CMD_UPDATE: begin
              if (in_row_ok) begin
                state_d = S_ACC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WR1: begin
        state_d = S_WR2;
      end
      S_WR2: begin
        state_d = S_DONE;
      end
      S_ACC: begin
        // Add the weight of an active unit, then its bias pass if enabled.
        if (particle_q[j_q]) begin
          field_d = alu_sat;
        end
        if (particle_q[j_q] && bias_mode_q) begin
          state_d = S_BIAS;
        end else if (j_q == LAST_J) begin
          state_d = S_LOOK;
        end else begin
          j_d = j_q + RW'(1);
        end
      end
      S_BIAS: begin
        field_d = alu_sat;
        if (j_q == LAST_J) begin
          state_d = S_LOOK;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_ACC;
        end
      end
      S_LOOK: begin
        bit_d               = draw_bit;
        particle_d[row_q_a] = draw_bit;
        state_d             = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register frees up.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, field_q, bit_q, part_x[bgu_pkg::PART_W-1:0]};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      j_q         <= '0;
      particle_q  <= '0;
      bias_mode_q <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= bgu_pkg::CMD_WRITE_WEIGHT;
      row_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      j_q         <= j_d;
      particle_q  <= particle_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
      row_q       <= row_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bias_mode_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    val_q      <= val_d;
    rnd_q      <= rnd_d;
    field_q    <= field_d;
    bit_q      <= bit_d;
    out_data_q <= out_data_d;
  end

  // ---------------------------------------------------------------------------
  // Weight and bias RAMs: one write port each, read address follows next state
  // so the read data lines up with j_q and row_q.
  // ---------------------------------------------------------------------------
  logic                   w_we;
  logic [AW-1:0]          w_waddr;
  logic [WEIGHT_BITS-1:0] w_wdata;
  logic                   b_we;
  logic [RW-1:0]          b_waddr;
  logic [WEIGHT_BITS-1:0] b_wdata;

  always_comb begin
    w_we    = 1'b0;
    w_waddr = clr_q;
    w_wdata = '0;
    b_we    = 1'b0;
    b_waddr = clr_q[RW-1:0];
    b_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        w_we = 1'b1;
        b_we = 1'b1;
      end
      S_IDLE: begin
        if (in_acc && (in_cmd == bgu_pkg::CMD_WRITE_BIAS) && in_row_ok) begin
          b_we    = 1'b1;
          b_waddr = in_row_a;
          b_wdata = in_val_w;
        end
      end
      S_WR1: begin
        w_we    = 1'b1;
        w_waddr = {row_q_a, col_q_a};
        w_wdata = (row_q == col_q) ? '0 : val_q;
      end
      S_WR2: begin
        w_we    = 1'b1;
        w_waddr = {col_q_a, row_q_a};
        w_wdata = (row_q == col_q) ? '0 : val_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    wrd_q <= wmem[{row_d_a, j_d}];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bmem[b_waddr] <= b_wdata;
    end
    brd_q <= bmem[row_d_a];
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign cfg_ready_o     = 1'b1;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_look_sets_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |=> (particle_q[row_q_a] == bit_q))
    else $error("updated unit does not hold the drawn bit");

  a_idle_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cmd_q != bgu_pkg::CMD_UPDATE) |-> (field_q == '0 && !bit_q))
    else $error("non-update command carries a field or bit");

  a_clear_particle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_cmd == bgu_pkg::CMD_CLEAR) |=> (particle_q == '0))
    else $error("clear command left active units");

  a_j_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC || state_q == S_BIAS) |-> (j_q <= LAST_J))
    else $error("unit counter ran past the last unit");

endmodule

// ===== dv/boltzmann_gibbs_unit_update_test.sv =====
// Self-checking bench for the Gibbs unit update block: directed table, then random phases.
`timescale 1ns / 1ps

module boltzmann_gibbs_unit_update_test;
  import bgu_pkg::*;

  localparam int NUM_UNITS    = 8;
  localparam int PHASE_ITEMS  = 110;     // random items per bias-mode phase
  localparam int NUM_PHASES   = 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 40;

  // One result item as the block reports it.
  typedef struct {
    logic [PART_W-1:0]         particle;
    logic                      new_bit;
    logic signed [FIELD_W-1:0] field;
  } gibbs_result_t;

  // One input item plus an optional hand-written expectation.
  typedef struct {
    cmd_e                      cmd;
    logic [ROW_W-1:0]          row;
    logic [ROW_W-1:0]          col;
    logic signed [VAL_W-1:0]   val;
    logic [RND_W-1:0]          rnd;
    bit                        typed;
    logic [PART_W-1:0]         e_particle;
    logic                      e_bit;
    logic signed [FIELD_W-1:0] e_field;
  } stim_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [CMD_W-1:0]      s_axis_tuser_i  = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic                  cfg_data_i      = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;

  // Shadow of the block: weights, biases, particle, mode and the sigmoid lookup.
  logic signed [VAL_W-1:0] weight_mem [NUM_UNITS][NUM_UNITS];
  logic signed [VAL_W-1:0] bias_mem   [NUM_UNITS];
  logic [NUM_UNITS-1:0]    unit_bits;
  logic                    bias_sub;
  logic [15:0]             sigmoid_lut [256];

  gibbs_result_t pending_results [$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            items_sent     = 0;
  int            stall_left     = 0;

  // Directed part: rows with typed=1 carry a hand-written expectation.
  stim_row_t dir_tab [15] = '{
    // empty particle, field 0 maps to 0.5: random at the top loses, random 0 wins
    '{CMD_UPDATE,       3'd0, 3'd0, 16'sh0000, 16'hFFFF, 1'b1, 8'h00, 1'b0, 21'sd0},
    '{CMD_UPDATE,       3'd0, 3'd0, 16'sh0000, 16'h0000, 1'b1, 8'h01, 1'b1, 21'sd0},
    // writes leave the particle alone and report zeros
    '{CMD_WRITE_WEIGHT, 3'd1, 3'd0, 16'sh7FFF, 16'h0000, 1'b1, 8'h01, 1'b0, 21'sd0},
    '{CMD_WRITE_WEIGHT, 3'd7, 3'd7, 16'sh8000, 16'hFFFF, 1'b1, 8'h01, 1'b0, 21'sd0},
    '{CMD_WRITE_WEIGHT, 3'd0, 3'd7, 16'sh8000, 16'h0000, 1'b1, 8'h01, 1'b0, 21'sd0},
    '{CMD_WRITE_BIAS,   3'd1, 3'd7, 16'sh7FFF, 16'hFFFF, 1'b1, 8'h01, 1'b0, 21'sd0},
    '{CMD_WRITE_BIAS,   3'd7, 3'd0, 16'sh8000, 16'h0000, 1'b1, 8'h01, 1'b0, 21'sd0},
    // largest positive and negative weight through the table ends
    '{CMD_UPDATE,       3'd1, 3'd0, 16'sh0000, 16'hFFFF, 1'b0, 8'h00, 1'b0, 21'sd0},
    '{CMD_UPDATE,       3'd7, 3'd0, 16'sh0000, 16'h0000, 1'b0, 8'h00, 1'b0, 21'sd0},
    '{CMD_CLEAR,        3'd5, 3'd2, 16'sh1234, 16'h5678, 1'b1, 8'h00, 1'b0, 21'sd0},
    // probability exactly one half must strictly beat the random value
    '{CMD_UPDATE,       3'd3, 3'd0, 16'sh0000, 16'h8000, 1'b1, 8'h00, 1'b0, 21'sd0},
    '{CMD_UPDATE,       3'd3, 3'd0, 16'sh0000, 16'h7FFF, 1'b1, 8'h08, 1'b1, 21'sd0},
    '{CMD_WRITE_WEIGHT, 3'd3, 3'd5, 16'sh1000, 16'h0000, 1'b1, 8'h08, 1'b0, 21'sd0},
    '{CMD_UPDATE,       3'd5, 3'd0, 16'sh0000, 16'h8000, 1'b0, 8'h00, 1'b0, 21'sd0},
    '{CMD_UPDATE,       3'd3, 3'd0, 16'sh0000, 16'hFFFF, 1'b0, 8'h00, 1'b0, 21'sd0}
  };

  boltzmann_gibbs_unit_update DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_data_i      (cfg_data_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o)
  );

  always #5 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 16);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_field(int v);
    if (v > FIELD_MAX) return FIELD_MAX;
    if (v < FIELD_MIN) return FIELD_MIN;
    return v;
  endfunction

  // Apply one item to the shadow state and return the result it must produce.
  function automatic gibbs_result_t gibbs_predict(stim_row_t it);
    gibbs_result_t res;
    int            acc;
    int            t;
    int            idx;
    res.new_bit = 1'b0;
    acc = 0;
    case (it.cmd)
      CMD_WRITE_WEIGHT: begin
        // diagonal always stores zero; a 16-bit value already fits the store
        weight_mem[it.row][it.col] = (it.row == it.col) ? '0 : it.val;
        weight_mem[it.col][it.row] = (it.row == it.col) ? '0 : it.val;
      end
      CMD_WRITE_BIAS: begin
        bias_mem[it.row] = it.val;
      end
      CMD_CLEAR: begin
        unit_bits = '0;
      end
      CMD_UPDATE: begin
        // every addition saturates on its own, bias comes off once per active unit
        for (int j = 0; j < NUM_UNITS; j++) begin
          if (unit_bits[j]) begin
            acc = clamp_field(acc + int'(weight_mem[it.row][j]));
            if (bias_sub) acc = clamp_field(acc - int'(bias_mem[it.row]));
          end
        end
        // table step is 1/16, clamped outside [-8, 8)
        t = acc + LUT_OFFSET;
        if (t < 0) idx = 0;
        else idx = ((t >>> 8) > 255) ? 255 : (t >>> 8);
        res.new_bit = (sigmoid_lut[idx] > it.rnd);
        unit_bits[it.row] = res.new_bit;
      end
      default: begin
      end
    endcase
    res.particle = unit_bits;
    res.field    = acc[FIELD_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one item; entered and left just after a falling edge. Valid stays high on
  // return so a back-to-back item needs no drop.
  task automatic send_item(stim_row_t it);
    int            gap;
    gibbs_result_t res;
    // hold off idling inside quiet windows so some stretches run at full rate
    gap = ((items_sent % 120) < 20) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  = {2'b00, it.rnd, it.val, it.col, it.row};
    s_axis_tuser_i  = it.cmd;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = gibbs_predict(it);
    if (it.typed) begin
      res.particle = it.e_particle;
      res.new_bit  = it.e_bit;
      res.field    = it.e_field;
    end
    pending_results.push_back(res);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Write the mode register once every result is home and the block is idle.
  task automatic set_bias_mode(logic mode);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    cfg_data_i  = mode;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    bias_sub = mode;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver back-pressure: random stalls, with no new stall started in every third window.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i = 1'b0;
    end else begin
      m_axis_tready_i = 1'b1;
      if ((cycle_count / 700) % 3 != 0 && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
    end
  end

  // Compare each accepted result item with the oldest expectation, field by field.
  always @(posedge clk_i) begin : check_results
    gibbs_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[7:0] !== want.particle)
          report_mismatch("particle", m_axis_tdata_o[7:0], want.particle);
        if (m_axis_tdata_o[8] !== want.new_bit)
          report_mismatch("new_bit", m_axis_tdata_o[8], want.new_bit);
        if (m_axis_tdata_o[29:9] !== want.field)
          report_mismatch("local_field", m_axis_tdata_o[29:9], want.field[FIELD_W-1:0]);
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : run
    longint unsigned exp_q30 [0:128];
    longint unsigned den;
    longint unsigned q;
    int              m;
    int              roll;
    stim_row_t       it;

    // Shadow reset state.
    for (int r = 0; r < NUM_UNITS; r++) begin
      bias_mem[r] = '0;
      for (int c = 0; c < NUM_UNITS; c++) weight_mem[r][c] = '0;
    end
    unit_bits = '0;
    bias_sub  = 1'b0;

    // Sigmoid lookup: exp(-m/16) in Q2.30 by repeated rounding multiply, then
    // 1/(1+exp(-|x|)) in Q0.16, mirrored for negative x.
    exp_q30[0] = 64'd1 << 30;
    for (int n = 0; n < 128; n++)
      exp_q30[n+1] = (exp_q30[n] * 64'd1008687096 + (64'd1 << 29)) >> 30;
    for (int k = 0; k < 256; k++) begin
      m   = (k >= 128) ? k - 128 : 128 - k;
      den = (64'd1 << 30) + exp_q30[m];
      q   = ((64'd1 << 46) + den / 2) / den;
      if (k >= 128) sigmoid_lut[k] = (q > 65535) ? 16'hFFFF : q[15:0];
      else sigmoid_lut[k] = 16'(64'd65536 - q);
    end

    // Reset once; the block then sweeps its RAMs before taking items.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    // Random phases alternate the bias mode, starting with subtraction on.
    it.typed      = 1'b0;
    it.e_particle = '0;
    it.e_bit      = 1'b0;
    it.e_field    = '0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_bias_mode(ph % 2 == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        it.cmd = (roll < 30) ? CMD_WRITE_WEIGHT :
                 (roll < 40) ? CMD_WRITE_BIAS :
                 (roll < 44) ? CMD_CLEAR : CMD_UPDATE;
        it.row = $urandom_range(0, 7);
        it.col = $urandom_range(0, 7);
        // mix table-end extremes with mid-range values that land inside the table
        roll = $urandom_range(0, 99);
        if (roll < 10)      it.val = 16'sh7FFF;
        else if (roll < 20) it.val = 16'sh8000;
        else if (roll < 55) it.val = 16'($urandom_range(0, 8191) - 4096);
        else                it.val = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 8)       it.rnd = 16'h0000;
        else if (roll < 16) it.rnd = 16'hFFFF;
        else                it.rnd = 16'($urandom);
        send_item(it);
      end
    end

    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bgu_pkg.sv
sv/bgu_sat_add.sv
sv/boltzmann_gibbs_unit_update.sv
dv/boltzmann_gibbs_unit_update_test.sv
